// ===== hdl/ssc_pkg.sv =====
// Shared types and codes for the shadow return stack checker.
// Used by the cell, the top level and the port checker; no dependencies.
package ssc_pkg;

	// Command codes carried on the command port
	localparam logic CMD_CALL   = 1'b0;
	localparam logic CMD_RETURN = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_MISMATCH  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned DEPTH_W = 7;

	// Shift control broadcast to every stack cell
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

// ===== hdl/shadow_return_stack_checker.sv =====
// Top level of the shadow return stack checker: a row of stack cells,
// the entry counter and the result register. Depends on ssc_pkg, ssc_cell.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  item in | command, address                        | start && !busy
//  result  | status, expected_address, stack_depth   | done, one cycle, no stall
//
// One item per cycle; its result shows with done in the cycle after accept.
// The top of stack lives in cell 0, so the compare and all cell shifts
// complete in the accepting cycle; busy stays low.
// Reset clears the entry count and done; cell contents are left as they are.
module shadow_return_stack_checker #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic [ssc_pkg::ADDR_W-1:0]  address,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [ssc_pkg::ADDR_W-1:0]  expected_address,
	output logic [ssc_pkg::DEPTH_W-1:0] stack_depth
);
	import ssc_pkg::*;

	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic              accept;
	logic              is_full;
	logic              is_empty;
	shift_ctl_t        ctl;
	status_t           status_next;
	logic [ADDR_W-1:0] expected_next;
	logic [ADDR_W-1:0] entries [STACK_DEPTH];

	logic              done_q;
	status_t           status_q;
	logic [ADDR_W-1:0] expected_q;
	logic [CNT_W-1:0]  depth_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign is_empty = (count_q == '0);

	// Decide shift, status and new count for the accepted item
	always_comb begin
		ctl           = '0;
		status_next   = ST_OK;
		expected_next = '0;
		count_next    = count_q;
		if (accept) begin
			if (command == CMD_CALL) begin
				if (is_full) begin
					status_next = ST_OVERFLOW;
				end else begin
					ctl.push   = 1'b1;
					count_next = count_q + 1'b1;
				end
			end else begin
				if (is_empty) begin
					status_next = ST_UNDERFLOW;
				end else begin
					ctl.pop       = 1'b1;
					count_next    = count_q - 1'b1;
					expected_next = entries[0];
					if (entries[0] != address) begin
						status_next = ST_MISMATCH;
					end
				end
			end
		end
	end

	// Row of stack cells, top of stack in cell 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [ADDR_W-1:0] above;
		logic [ADDR_W-1:0] below;
		if (i == 0) begin : g_top
			assign above = address;
		end else begin : g_mid
			assign above = entries[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = '0;
		end else begin : g_up
			assign below = entries[i+1];
		end
		ssc_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above (above),
			.from_below (below),
			.entry      (entries[i])
		);
	end

	// Advance entry count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	// Hold the result payload for its one-cycle transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_next;
			expected_q <= expected_next;
			depth_q    <= count_next;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign expected_address = expected_q;
	assign stack_depth      = DEPTH_W'(depth_q);

endmodule

// ===== hdl/ssc_cell.sv =====
// One entry of the shift-register return stack.
// Depends on ssc_pkg for the shift control struct and address width.
module ssc_cell (
	input  logic                       clk,
	input  ssc_pkg::shift_ctl_t        ctl,
	input  logic [ssc_pkg::ADDR_W-1:0] from_above,
	input  logic [ssc_pkg::ADDR_W-1:0] from_below,
	output logic [ssc_pkg::ADDR_W-1:0] entry
);
	import ssc_pkg::*;

	logic [ADDR_W-1:0] entry_q;

	// Shift down on push, up on pop, hold otherwise
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_above;
		end else if (ctl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

// ===== hdl/ssc_port_check.sv =====
// Port-level checks for the shadow return stack checker, bound to the top.
// Depends on ssc_pkg for the status codes.
module ssc_port_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [ssc_pkg::ADDR_W-1:0]  expected_address,
	input logic [ssc_pkg::DEPTH_W-1:0] stack_depth
);
	import ssc_pkg::*;

	// Every accepted item yields a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted item gave no result");

	// No result appears without an accepted item
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without accepted item");

	// Underflow leaves an empty stack and no popped address
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_UNDERFLOW) |-> (stack_depth == '0 && expected_address == '0))
		else $error("underflow result with entries or address");

	// Overflow pops nothing
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OVERFLOW) |-> expected_address == '0)
		else $error("overflow result with address");

	// Back-to-back overflow results keep the depth where it was
	a_overflow_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && status == ST_OVERFLOW && $past(status) == ST_OVERFLOW)
		|-> $stable(stack_depth))
		else $error("depth moved on repeated overflow");

endmodule

bind shadow_return_stack_checker ssc_port_check u_ssc_port_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.status           (status),
	.expected_address (expected_address),
	.stack_depth      (stack_depth)
);

// ===== verif/shadow_return_stack_checker_test.sv =====
// Self-checking bench for shadow_return_stack_checker: random and directed call/return
// traffic, with a shadow stack that predicts every status, address and depth.
// Depends on ssc_pkg and the shadow_return_stack_checker RTL only.
`timescale 1ns / 100ps

module shadow_return_stack_checker_test;
	import ssc_pkg::*;

	localparam int unsigned STACK_DEPTH = 64;

	typedef struct {
		status_t            status;
		logic [ADDR_W-1:0]  expected_address;
		logic [DEPTH_W-1:0] stack_depth;
	} stack_result_t;

	// Shadow stack: predicts each result when a transfer is accepted, checks results in order
	class return_stack_scoreboard;
		logic [ADDR_W-1:0] shadow_stack [STACK_DEPTH];
		int unsigned       entry_count = 0;
		stack_result_t     pending_results [$];
		int unsigned       error_count = 0;

		function void record_item(logic cmd, logic [ADDR_W-1:0] addr);
			stack_result_t r;
			r.status           = ST_OK;
			r.expected_address = '0;
			if (cmd == CMD_CALL) begin
				if (entry_count >= STACK_DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					shadow_stack[entry_count] = addr;
					entry_count++;
				end
			end else if (entry_count == 0) begin
				r.status = ST_UNDERFLOW;
			end else begin
				entry_count--;
				r.expected_address = shadow_stack[entry_count];
				if (r.expected_address != addr) begin
					r.status = ST_MISMATCH;
				end
			end
			r.stack_depth = DEPTH_W'(entry_count);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [ADDR_W-1:0] ea,
				logic [DEPTH_W-1:0] depth);
			stack_result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no transfer outstanding: status %0d address %h depth %0d",
					st, ea, depth);
				error_count++;
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				error_count++;
			end
			if (ea !== want.expected_address) begin
				$error("expected_address: expected %h, actual %h", want.expected_address, ea);
				error_count++;
			end
			if (depth !== want.stack_depth) begin
				$error("stack_depth: expected %0d, actual %0d", want.stack_depth, depth);
				error_count++;
			end
		endfunction

		function logic [ADDR_W-1:0] top_entry();
			return (entry_count == 0) ? '0 : shadow_stack[entry_count - 1];
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               command;
	logic [ADDR_W-1:0]  address;
	logic               done;
	logic [1:0]         status;
	logic [ADDR_W-1:0]  expected_address;
	logic [DEPTH_W-1:0] stack_depth;

	return_stack_scoreboard sb = new;
	bit                     no_idle = 0;

	shadow_return_stack_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.address(address),
		.done(done),
		.status(status),
		.expected_address(expected_address),
		.stack_depth(stack_depth)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#200000;
		$display("shadow_return_stack_checker_test: errors");
		$finish;
	end

	// Note accepted transfers and check results at each rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.record_item(command, address);
			end
			if (done) begin
				sb.check_result(status, expected_address, stack_depth);
			end
		end
	end

	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 4) return '0;
		if (sel < 8) return '1;
		if (sel < 12) return {{(ADDR_W-1){1'b0}}, 1'b1} << $urandom_range(ADDR_W-1);
		return {$urandom, $urandom};
	endfunction

	// Return target: usually the predicted top, sometimes a corrupted one
	function automatic logic [ADDR_W-1:0] pick_return_target(int unsigned match_pct);
		if ($urandom_range(99) < match_pct) return sb.top_entry();
		if ($urandom_range(1)) return sb.top_entry() ^ (64'd1 << $urandom_range(ADDR_W-1));
		return pick_address();
	endfunction

	// Drive one item from a falling edge, with random idle cycles ahead of it
	task automatic issue_item(input logic cmd, input logic [ADDR_W-1:0] addr);
		while (!no_idle && $urandom_range(99) < 13) begin
			start   <= 1'b0;
			command <= 1'($urandom);
			address <= {$urandom, $urandom};
			@(negedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		address <= addr;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Hold off the sender until every predicted result has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending_results.size() != 0) @(negedge clk);
	endtask

	initial begin
		int unsigned call_pct;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		command <= CMD_CALL;
		address <= '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: underflow, field extremes, nesting, mismatches
		issue_item(CMD_RETURN, '1);
		issue_item(CMD_CALL, '1);
		issue_item(CMD_RETURN, '1);
		issue_item(CMD_CALL, '0);
		issue_item(CMD_RETURN, '0);
		issue_item(CMD_CALL, 64'h5555_5555_5555_5555);
		issue_item(CMD_RETURN, 64'hAAAA_AAAA_AAAA_AAAA);
		issue_item(CMD_CALL, 64'h8000_0000_0000_0000);
		issue_item(CMD_CALL, 64'h0000_0000_0000_0001);
		issue_item(CMD_RETURN, 64'h0000_0000_0000_0001);
		issue_item(CMD_RETURN, 64'h8000_0000_0000_0000);
		issue_item(CMD_CALL, 64'h0123_4567_89AB_CDEF);
		issue_item(CMD_RETURN, 64'h0123_4567_89AB_CDEE);
		issue_item(CMD_RETURN, '0);
		hold_until_drained();

		// Nested call/return walk with mostly matching returns
		for (int i = 0; i < 250; i++) begin
			no_idle = (i >= 90 && i < 170);
			if (sb.entry_count == 0) call_pct = 100;
			else if (sb.entry_count < 8) call_pct = 65;
			else if (sb.entry_count < 40) call_pct = 50;
			else call_pct = 30;
			if ($urandom_range(99) < call_pct) begin
				issue_item(CMD_CALL, pick_address());
			end else begin
				issue_item(CMD_RETURN, pick_return_target(90));
			end
		end
		no_idle = 0;
		hold_until_drained();

		// Fill to full depth, push past it, unwind, then pop past empty
		while (sb.entry_count < STACK_DEPTH) issue_item(CMD_CALL, pick_address());
		repeat (3) issue_item(CMD_CALL, pick_address());
		while (sb.entry_count > 0) issue_item(CMD_RETURN, pick_return_target(95));
		repeat (2) issue_item(CMD_RETURN, pick_address());
		hold_until_drained();

		// Unstructured noise
		for (int i = 0; i < 100; i++) begin
			issue_item(1'($urandom), pick_address());
		end

		hold_until_drained();
		repeat (4) @(negedge clk);
		if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
			$display("shadow_return_stack_checker_test: clean");
		end else begin
			$display("shadow_return_stack_checker_test: errors");
		end
		$finish;
	end

endmodule

// ===== shadow_return_stack_checker.f =====
hdl/ssc_pkg.sv
hdl/ssc_cell.sv
hdl/shadow_return_stack_checker.sv
hdl/ssc_port_check.sv
verif/shadow_return_stack_checker_test.sv
